// File: sv/assert_macros.svh
// Concurrent assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising clk edge outside reset.
`define GZ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("gzip header stripper: assertion failed");

// Check that post holds in the cycle after pre.
`define GZ_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("gzip header stripper: sequence check failed");

`else

`define GZ_ASSERT(lbl, clk, rst_n, prop)
`define GZ_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

// File: sv/gzhs_pkg.sv
package gzhs_pkg;

    // Width of the saturating header byte counter.
    localparam int LEN_BITS = 20;
    // Width of the header_length field on the result channel.
    localparam int HL_BITS  = 20;

    localparam int         FIXED_LEN    = 10;
    localparam logic [7:0] METHOD_DEFL  = 8'h08;
    localparam logic [7:0] FLG_HCRC     = 8'h02;
    localparam logic [7:0] FLG_EXTRA    = 8'h04;
    localparam logic [7:0] FLG_NAME     = 8'h08;
    localparam logic [7:0] FLG_COMMENT  = 8'h10;
    localparam logic [7:0] FLG_RESERVED = 8'he0;

    typedef enum logic [3:0] {
        PH_FIXED   = 4'd0,
        PH_EXLO    = 4'd1,
        PH_EXHI    = 4'd2,
        PH_EXDATA  = 4'd3,
        PH_NAME    = 4'd4,
        PH_COMMENT = 4'd5,
        PH_CRC1    = 4'd6,
        PH_CRC2    = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_ERROR   = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2,
        KIND_TRUNC   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         payload_byte;
        logic [HL_BITS-1:0] header_length;
        logic               first_payload;
        logic               stream_end;
    } t_result;

endpackage

// File: sv/gzhs_stream_if.sv
// Byte channel into the stripper.
interface gzhs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel out of the stripper.
interface gzhs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [19:0] header_length;
    logic        first_payload;
    logic        stream_end;

    modport source (output valid, output kind, output payload_byte, output header_length,
                    output first_payload, output stream_end, input ready);
    modport sink   (input valid, input kind, input payload_byte, input header_length,
                    input first_payload, input stream_end, output ready);
endinterface

// File: sv/gzhs_parse.sv
module gzhs_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  gzhs_pkg::t_item  i_item,
    output gzhs_pkg::t_result o_result
);
    import gzhs_pkg::*;

    t_phase              r_phase, n_phase;
    logic [LEN_BITS-1:0] r_pos, n_pos;
    logic [7:0]          r_flags, n_flags;
    logic [15:0]         r_extra, n_extra;
    logic                r_seen, n_seen;

    logic [LEN_BITS-1:0] pos_inc;
    logic [15:0]         extra_full;
    logic                err;
    logic [31:0]         pos_wide;

    // Pick the first optional part at or after 'from' whose flag is set.
    function automatic t_phase next_phase(input t_phase from, input logic [7:0] flags);
        t_phase res;
        if (from <= PH_EXLO && (flags & FLG_EXTRA) != 8'h00) begin
            res = PH_EXLO;
        end else if (from <= PH_NAME && (flags & FLG_NAME) != 8'h00) begin
            res = PH_NAME;
        end else if (from <= PH_COMMENT && (flags & FLG_COMMENT) != 8'h00) begin
            res = PH_COMMENT;
        end else if (from <= PH_CRC1 && (flags & FLG_HCRC) != 8'h00) begin
            res = PH_CRC1;
        end else begin
            res = PH_PAYLOAD;
        end
        return res;
    endfunction

    assign pos_inc    = (r_pos == '1) ? r_pos : r_pos + LEN_BITS'(1);
    assign extra_full = {i_item.data_byte, r_extra[7:0]};
    assign pos_wide   = 32'(r_pos);

    // Bad method on byte two, reserved flag bits on byte three.
    assign err = (r_phase == PH_FIXED) &&
                 ((r_pos == LEN_BITS'(2) && i_item.data_byte != METHOD_DEFL) ||
                  (r_pos == LEN_BITS'(3) && (i_item.data_byte & FLG_RESERVED) != 8'h00));

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_flags = r_flags;
        n_extra = r_extra;
        n_seen  = r_seen;
        case (r_phase)
            PH_FIXED: begin
                if (r_pos == LEN_BITS'(3)) begin
                    n_flags = i_item.data_byte;
                end
                n_pos = pos_inc;
                if (r_pos == LEN_BITS'(FIXED_LEN - 1)) begin
                    n_phase = next_phase(PH_EXLO, r_flags);
                end
            end
            PH_EXLO: begin
                n_extra = {8'h00, i_item.data_byte};
                n_pos   = pos_inc;
                n_phase = PH_EXHI;
            end
            PH_EXHI: begin
                n_extra = extra_full;
                n_pos   = pos_inc;
                n_phase = (extra_full != 16'h0000) ? PH_EXDATA : next_phase(PH_NAME, r_flags);
            end
            PH_EXDATA: begin
                if (r_extra != 16'h0000) begin
                    n_extra = r_extra - 16'd1;
                end
                n_pos = pos_inc;
                if (r_extra <= 16'd1) begin
                    n_phase = next_phase(PH_NAME, r_flags);
                end
            end
            PH_NAME: begin
                n_pos = pos_inc;
                if (i_item.data_byte == 8'h00) begin
                    n_phase = next_phase(PH_COMMENT, r_flags);
                end
            end
            PH_COMMENT: begin
                n_pos = pos_inc;
                if (i_item.data_byte == 8'h00) begin
                    n_phase = next_phase(PH_CRC1, r_flags);
                end
            end
            PH_CRC1: begin
                n_pos   = pos_inc;
                n_phase = PH_CRC2;
            end
            PH_CRC2: begin
                n_pos   = pos_inc;
                n_phase = next_phase(PH_PAYLOAD, r_flags);
            end
            PH_PAYLOAD: begin
                n_seen = 1'b1;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        if (err) begin
            n_phase = PH_ERROR;
        end
        // Return to the start after the final byte of a buffer.
        if (i_item.last_byte) begin
            n_phase = PH_FIXED;
            n_pos   = '0;
            n_flags = 8'h00;
            n_extra = 16'h0000;
            n_seen  = 1'b0;
        end
    end

    // Outputs
    always_comb begin
        o_result               = '0;
        o_result.stream_end    = i_item.last_byte;
        case (r_phase)
            PH_FIXED, PH_EXLO, PH_EXHI, PH_EXDATA,
            PH_NAME, PH_COMMENT, PH_CRC1, PH_CRC2: begin
                o_result.kind = KIND_HEADER;
            end
            PH_PAYLOAD: begin
                o_result.kind          = KIND_PAYLOAD;
                o_result.payload_byte  = i_item.data_byte;
                o_result.header_length = pos_wide[HL_BITS-1:0];
                o_result.first_payload = ~r_seen;
            end
            default: begin
                o_result.kind = KIND_ERROR;
            end
        endcase
        if (err) begin
            o_result.kind = KIND_ERROR;
        end else if (o_result.kind == KIND_HEADER && i_item.last_byte) begin
            o_result.kind = KIND_TRUNC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIXED;
            r_pos   <= '0;
            r_flags <= 8'h00;
            r_extra <= 16'h0000;
            r_seen  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_flags <= n_flags;
            r_extra <= n_extra;
            r_seen  <= n_seen;
        end
    end

endmodule

// File: sv/gzip_header_stripper_unit.sv
// Channel    Dir  Modport         Carries
// i_in       in   gzhs_in_if      data_byte, last_byte
// o_out      out  gzhs_out_if     kind, payload_byte, header_length, first_payload, stream_end
//
// One byte per cycle sustained while o_out accepts results; each transaction yields exactly one result.
// A byte passes the input register, then the result register; the phase updates as the result register loads.
// The rate is set by the single phase/counter update in gzhs_parse, done once per byte.
// Synchronous active-low reset clears both valid flags and the parse state.
// A stall on o_out holds the result register, then the input register, then drops i_in.ready.
`include "assert_macros.svh"

module gzip_header_stripper_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gzhs_in_if.sink           i_in,
    gzhs_out_if.source        o_out
);
    import gzhs_pkg::*;

    // Input register stage
    logic    r_in_valid;
    t_item   r_in_item;

    // Result register stage
    logic    r_out_valid;
    t_result r_out;

    logic    out_free;   // result register can take a new transaction
    logic    advance;    // move the held byte through the parser
    t_result parse_result;
    t_item   in_item;

    assign in_item.data_byte = i_in.data_byte;
    assign in_item.last_byte = i_in.last_byte;

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || advance;

    // Parser: state advances only when its byte moves into the result register.
    gzhs_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .o_result (parse_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Refill the input register whenever it empties or advances.
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            // Load or drain the result register.
            if (out_free) begin
                r_out_valid <= advance;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= in_item;
        end
        if (advance) begin
            r_out <= parse_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out.kind;
    assign o_out.payload_byte  = r_out.payload_byte;
    assign o_out.header_length = r_out.header_length;
    assign o_out.first_payload = r_out.first_payload;
    assign o_out.stream_end    = r_out.stream_end;

    // A stalled byte in the input register stays put.
    `GZ_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid && $stable(r_in_item))

    // A blocked result stays valid.
    `GZ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !o_out.ready, r_out_valid)

    // First-payload mark and header length appear only on payload results.
    `GZ_ASSERT(a_payload_only, i_clk, i_rst_n, !r_out_valid || r_out.kind == KIND_PAYLOAD || (!r_out.first_payload && r_out.header_length == '0))

endmodule
